>>> sv/ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define UER_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define UER_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UER_ASSERT(lbl, prop, msg)
`define UER_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> sv/uer_pkg.sv
// Types, constants and register map of the ultrasonic echo ranger.
package uer_pkg;

	localparam int COUNT_BITS_DEF = 20;

	localparam int TRIG_W    = 10;
	localparam int SETTLE_W  = 16;
	localparam int TIMEOUT_W = 20;
	localparam int SPEED_W   = 9;
	localparam int STATUS_W  = 2;
	localparam int WIDTH_W   = 20;
	localparam int DIST_W    = 21;

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int IDX_LSB = 2;

	localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(10);
	localparam logic [SETTLE_W-1:0]  SETTLE_RST  = SETTLE_W'(100);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100000);
	localparam logic [SPEED_W-1:0]   SPEED_RST   = SPEED_W'(343);

	// Distance = width * speed / 200, kept as a running quotient and remainder.
	localparam int DIV_CONST = 200;
	localparam int REM_W     = 8;
	localparam int SUM_W     = 10;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_RISE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG,
		PH_SETTLE,
		PH_RISE,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		REG_TRIGGER,
		REG_SETTLE,
		REG_TIMEOUT,
		REG_SPEED
	} reg_idx_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} uer_in_t;

	typedef struct packed {
		logic                trigger_out;
		logic                busy_res;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [WIDTH_W-1:0]  pulse_width;
		logic [DIST_W-1:0]   distance_centi_cm;
	} uer_out_t;

	typedef struct packed {
		logic [TRIG_W-1:0]    trigger_ticks;
		logic [SETTLE_W-1:0]  settle_ticks;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [SPEED_W-1:0]   sound_speed;
	} uer_cfg_t;

endpackage

>>> sv/uer_core.sv
// Measurement sequencer: trigger, settle, echo timing and distance accumulation.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_core import uer_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  uer_in_t  item,
	input  uer_cfg_t cfg,
	output uer_out_t res
);

	localparam int LW = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
	localparam logic [SUM_W-1:0] D1 = SUM_W'(DIV_CONST);
	localparam logic [SUM_W-1:0] D2 = SUM_W'(2 * DIV_CONST);
	localparam logic [SUM_W-1:0] D3 = SUM_W'(3 * DIV_CONST);

	phase_t ph_q, ph_eff, ph_d;
	logic [COUNT_BITS-1:0] tc_q, tc_eff, tc_d, tc_inc;
	logic [DIST_W-1:0] q_q, q_d, q_base, q_acc;
	logic [REM_W-1:0] r_q, r_d, r_base, r_acc;
	logic [SUM_W-1:0] r_sum;
	logic [1:0] q_step;
	logic [DIST_W:0] q_sum;
	logic [STATUS_W-1:0] st_q, st_d;
	logic [WIDTH_W-1:0] width_q, width_d;
	logic [DIST_W-1:0] dist_q, dist_d;
	logic [TRIG_W-1:0] tlen;
	logic [LW-1:0] tc_ext;
	logic limit;
	logic trig;
	logic done;

	// First half of the tick: leave idle or settle before the active phase runs.
	always_comb begin
		ph_eff = ph_q;
		tc_eff = tc_q;
		unique case (ph_q)
			PH_IDLE: begin
				if (item.start_req) begin
					ph_eff = PH_TRIG;
					tc_eff = '0;
				end
			end
			PH_SETTLE: begin
				if (LW'(tc_q) < LW'(cfg.settle_ticks)) begin
					tc_eff = tc_q + COUNT_BITS'(1);
				end else begin
					ph_eff = PH_RISE;
					tc_eff = '0;
				end
			end
			PH_TRIG, PH_RISE, PH_HIGH: begin
			end
			default: begin
				ph_eff = PH_IDLE;
				tc_eff = '0;
			end
		endcase
	end

	assign tc_inc = tc_eff + COUNT_BITS'(1);
	assign tc_ext = LW'(tc_eff);
	assign limit  = (tc_ext >= LW'(cfg.timeout_ticks)) || (tc_eff == '1);
	assign tlen   = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;

	// One more tick of echo adds sound_speed to the remainder; at most three
	// carries into the quotient since remainder plus speed stays below 800.
	always_comb begin
		q_base = (ph_eff == PH_RISE) ? '0 : q_q;
		r_base = (ph_eff == PH_RISE) ? '0 : r_q;
		r_sum  = SUM_W'(r_base) + SUM_W'(cfg.sound_speed);
		priority if (r_sum >= D3) begin
			q_step = 2'd3;
			r_acc  = REM_W'(r_sum - D3);
		end else if (r_sum >= D2) begin
			q_step = 2'd2;
			r_acc  = REM_W'(r_sum - D2);
		end else if (r_sum >= D1) begin
			q_step = 2'd1;
			r_acc  = REM_W'(r_sum - D1);
		end else begin
			q_step = 2'd0;
			r_acc  = REM_W'(r_sum);
		end
		q_sum = {1'b0, q_base} + (DIST_W + 1)'(q_step);
		q_acc = q_sum[DIST_W] ? DIST_MAX : q_sum[DIST_W-1:0];
	end

	// Second half of the tick: the active phase.
	always_comb begin
		ph_d    = ph_eff;
		tc_d    = tc_eff;
		q_d     = q_q;
		r_d     = r_q;
		st_d    = st_q;
		width_d = width_q;
		dist_d  = dist_q;
		trig    = 1'b0;
		done    = 1'b0;
		unique case (ph_eff)
			PH_TRIG: begin
				trig = 1'b1;
				if (LW'(tc_inc) >= LW'(tlen)) begin
					ph_d = PH_SETTLE;
					tc_d = '0;
				end else begin
					tc_d = tc_inc;
				end
			end
			PH_RISE: begin
				if (item.echo) begin
					ph_d = PH_HIGH;
					tc_d = COUNT_BITS'(1);
					q_d  = q_acc;
					r_d  = r_acc;
				end else if (limit) begin
					ph_d    = PH_IDLE;
					tc_d    = '0;
					st_d    = ST_NO_RISE;
					width_d = '0;
					dist_d  = '0;
					done    = 1'b1;
				end else begin
					tc_d = tc_inc;
				end
			end
			PH_HIGH: begin
				if (!item.echo) begin
					ph_d    = PH_IDLE;
					tc_d    = '0;
					st_d    = ST_OK;
					width_d = tc_ext[WIDTH_W-1:0];
					dist_d  = q_q;
					done    = 1'b1;
				end else if (limit) begin
					ph_d    = PH_IDLE;
					tc_d    = '0;
					st_d    = ST_TOO_LONG;
					width_d = '0;
					dist_d  = '0;
					done    = 1'b1;
				end else begin
					tc_d = tc_inc;
					q_d  = q_acc;
					r_d  = r_acc;
				end
			end
			PH_IDLE, PH_SETTLE: begin
			end
			default: begin
				ph_d = PH_IDLE;
				tc_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			tc_q    <= '0;
			q_q     <= '0;
			r_q     <= '0;
			st_q    <= ST_OK;
			width_q <= '0;
			dist_q  <= '0;
		end else if (step) begin
			ph_q    <= ph_d;
			tc_q    <= tc_d;
			q_q     <= q_d;
			r_q     <= r_d;
			st_q    <= st_d;
			width_q <= width_d;
			dist_q  <= dist_d;
		end
	end

	assign res.trigger_out       = trig;
	assign res.busy_res          = (ph_d != PH_IDLE);
	assign res.done_res          = done;
	assign res.status            = st_d;
	assign res.pulse_width       = width_d;
	assign res.distance_centi_cm = dist_d;

	`UER_ASSERT(a_done_idle, (step && res.done_res) |-> !res.busy_res, "finish left busy set")
	`UER_ASSERT(a_high_nonzero, (ph_q == PH_HIGH) |-> (tc_q != '0), "echo high with zero count")
	`UER_ASSERT(a_timeout_clear, (step && res.done_res && res.status != ST_OK) |=> (width_q == '0 && dist_q == '0), "timeout kept stale width or distance")

endmodule

>>> sv/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: tick channel, result channel, APB registers.
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid / in_stall       in_data  (uer_in_t: start_req, echo)
//   out       from block out_valid / out_stall     out_data (uer_out_t: six result fields)
//   cfg       to block   psel/penable/pwrite/pready paddr, pwdata, prdata (32-bit APB)
//
// Every accepted tick gives exactly one result transfer: it waits in the input register,
// then passes through the sequencer logic into the result register.
// A tick may be accepted in every cycle while in_stall is low; the rate is set by the
// per-tick update of the phase and counter registers in uer_core.
// Reset puts the registers at their defaults, the sequencer idle and the held
// status, width and distance at zero; there is no clearing pass.
// While out_stall holds the result register, the input register keeps its tick and
// in_stall rises once both are full.
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  uer_in_t           in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output uer_out_t          out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Config registers. Software must write them only while no measurement runs; unchecked.
	logic [TRIG_W-1:0]    trig_q;
	logic [SETTLE_W-1:0]  settle_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [SPEED_W-1:0]   speed_q;
	logic                 wr_en;
	reg_idx_t             reg_idx;
	uer_cfg_t             cfg;

	// Input register and result register.
	logic     valid_s1;
	uer_in_t  item_s1;
	logic     out_valid_s2;
	uer_out_t res_s2;
	uer_out_t res;
	logic     adv;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q    <= TRIG_RST;
			settle_q  <= SETTLE_RST;
			timeout_q <= TIMEOUT_RST;
			speed_q   <= SPEED_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TRIGGER: trig_q    <= pwdata[TRIG_W-1:0];
				REG_SETTLE:  settle_q  <= pwdata[SETTLE_W-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				REG_SPEED:   speed_q   <= pwdata[SPEED_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRIGGER: prdata = DATA_W'(trig_q);
			REG_SETTLE:  prdata = DATA_W'(settle_q);
			REG_TIMEOUT: prdata = DATA_W'(timeout_q);
			REG_SPEED:   prdata = DATA_W'(speed_q);
		endcase
	end

	assign cfg.trigger_ticks = trig_q;
	assign cfg.settle_ticks  = settle_q;
	assign cfg.timeout_ticks = timeout_q;
	assign cfg.sound_speed   = speed_q;

	// The held tick moves on whenever the result register is empty or being drained.
	assign adv      = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && out_valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	uer_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || !out_stall) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = res_s2;

	`UER_ASSERT(a_adv_fills, adv |=> out_valid_s2, "advanced tick did not reach the result register")
	`UER_ASSERT(a_cfg_trig, (wr_en && reg_idx == REG_TRIGGER) |=> (trig_q == $past(pwdata[TRIG_W-1:0])), "trigger length write lost")
	`UER_ASSERT_RST(a_reset_quiet, !arst_n |-> (!out_valid && !in_stall), "channel active during reset")

endmodule
